/* src/address_range_set_table_macros.svh */
// Assertion macros for the range table.
`ifndef ADDRESS_RANGE_SET_TABLE_MACROS_SVH
`define ADDRESS_RANGE_SET_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define ARST_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ARST_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define ARST_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ARST_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

/* src/arst_pkg.sv */
package arst_pkg;
  localparam int MaxRows = 256;
  localparam int IdxW = $clog2(MaxRows);
  localparam int CntW = IdxW + 1;
  localparam int RowW = 64;

  localparam logic [1:0] CMD_INS = 2'd0;
  localparam logic [1:0] CMD_DEL = 2'd1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SWAIT, S_RDP, S_RDQ, S_RWAIT, S_DECIDE,
    S_SHUP, S_SHDN, S_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [RowW-1:0] wdata;
    logic [IdxW-1:0] raddr;
  } mem_req_t;
endpackage

/* src/address_range_set_table.sv */
// Channel | Ports                                    | Transfer
// in      | start, busy, in_cmd, in_key              | start && !busy at clk edge
// out     | out_valid, out_status, out_hit,          | out_valid high one cycle,
//         | out_row_index, out_rows_used             | always taken
//
// One command at a time. A command runs a binary search on the row memory
// (one read, one compare per probe), a row fetch and decision, then on
// insert of a new row, a row split, a merge or a row removal shifts rows
// one by one through the memory's one read port and one write port, then
// writes back up to two rows and gives the result. Reset clears the state
// and the row count only; row contents beyond the count are never used.
// The receiver cannot stall.
module address_range_set_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_key,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic        out_hit,
  output logic [7:0]  out_row_index,
  output logic [8:0]  out_rows_used
);
  import arst_pkg::*;

  mem_req_t        mreq;
  logic [RowW-1:0] rdata;

  // row memory: {start, extra} per row
  arst_ram #(.Width(RowW), .Depth(MaxRows)) u_rows (
    .clk   (clk),
    .we    (mreq.we),
    .waddr (mreq.waddr),
    .wdata (mreq.wdata),
    .raddr (mreq.raddr),
    .rdata (rdata)
  );

  // search, decide, shift and write-back sequencer
  arst_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_key        (in_key),
    .done          (out_valid),
    .out_status    (out_status),
    .out_hit       (out_hit),
    .out_row_index (out_row_index),
    .out_rows_used (out_rows_used),
    .mreq          (mreq),
    .rdata         (rdata)
  );
endmodule

/* src/arst_ram.sv */
module arst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/arst_ctrl.sv */
`include "address_range_set_table_macros.svh"
module arst_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_cmd,
  input  logic [31:0]            in_key,
  output logic                   done,
  output logic [1:0]             out_status,
  output logic                   out_hit,
  output logic [7:0]             out_row_index,
  output logic [8:0]             out_rows_used,
  output arst_pkg::mem_req_t     mreq,
  input  logic [arst_pkg::RowW-1:0] rdata
);
  import arst_pkg::*;

  state_t state_r, state_nxt;
  logic [1:0]      cmd_r, cmd_nxt;
  logic [31:0]     key_r, key_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CntW-1:0] ptr_r, ptr_nxt;  // shift cursor
  logic [31:0]     ps_r, ps_nxt, pe_r, pe_nxt, qs_r, qs_nxt, qe_r, qe_nxt;
  logic            hit_r, hit_nxt;
  logic [1:0]      st_r, st_nxt;
  logic [CntW-1:0] lim_r, lim_nxt;  // shift stop row
  logic [RowW-1:0] nw_r, nw_nxt;    // row to write at end
  logic [IdxW-1:0] nwa_r, nwa_nxt;
  logic            nwv_r, nwv_nxt;
  logic [RowW-1:0] nw2_r, nw2_nxt;
  logic [IdxW-1:0] nw2a_r, nw2a_nxt;
  logic            nw2v_r, nw2v_nxt;
  logic [CntW-1:0] mid;
  logic            has_p, has_q;
  logic [CntW-1:0] p;
  logic [32:0]     pend;

  assign mid   = lo_r + ((hi_r - lo_r) >> 1);
  assign has_p = lo_r != '0;
  assign p     = lo_r - CntW'(1);
  assign has_q = lo_r < cnt_r;
  assign pend  = {1'b0, ps_r} + {1'b0, pe_r};
  assign busy  = state_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    cmd_r <= cmd_nxt; key_r <= key_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    ptr_r <= ptr_nxt; ps_r <= ps_nxt; pe_r <= pe_nxt; qs_r <= qs_nxt;
    qe_r <= qe_nxt; hit_r <= hit_nxt; st_r <= st_nxt; lim_r <= lim_nxt;
    nw_r <= nw_nxt; nwa_r <= nwa_nxt; nwv_r <= nwv_nxt;
    nw2_r <= nw2_nxt; nw2a_r <= nw2a_nxt; nw2v_r <= nw2v_nxt;
  end

  always_comb begin
    state_nxt = state_r; cmd_nxt = cmd_r; key_nxt = key_r; cnt_nxt = cnt_r;
    lo_nxt = lo_r; hi_nxt = hi_r; ptr_nxt = ptr_r; ps_nxt = ps_r; pe_nxt = pe_r;
    qs_nxt = qs_r; qe_nxt = qe_r; hit_nxt = hit_r; st_nxt = st_r;
    lim_nxt = lim_r; nw_nxt = nw_r; nwa_nxt = nwa_r; nwv_nxt = nwv_r;
    nw2_nxt = nw2_r; nw2a_nxt = nw2a_r; nw2v_nxt = nw2v_r;
    mreq = '0;
    done = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_cmd; key_nxt = in_key;
          lo_nxt = '0; hi_nxt = cnt_r;
          st_nxt = ST_OK; nwv_nxt = 1'b0; nw2v_nxt = 1'b0;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          mreq.raddr = mid[IdxW-1:0];
          state_nxt = S_SWAIT;
        end else begin
          state_nxt = S_RDP;
        end
      end
      S_SWAIT: begin
        if (rdata[63:32] <= key_r) lo_nxt = mid + CntW'(1);
        else hi_nxt = mid;
        state_nxt = S_SRCH;
      end
      S_RDP: begin
        mreq.raddr = p[IdxW-1:0];
        state_nxt = S_RDQ;
      end
      S_RDQ: begin
        ps_nxt = rdata[63:32]; pe_nxt = rdata[31:0];
        mreq.raddr = lo_r[IdxW-1:0];
        state_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        qs_nxt = rdata[63:32]; qe_nxt = rdata[31:0];
        hit_nxt = has_p && ({1'b0, key_r} <= pend);
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_WR;
        if (cmd_r == CMD_INS) begin
          if (!hit_r) begin
            if (has_p && pend + 33'd1 == {1'b0, key_r}) begin
              if (has_q && {1'b0, qs_r} == {1'b0, key_r} + 33'd1) begin
                nwv_nxt = 1'b1; nwa_nxt = p[IdxW-1:0];
                nw_nxt = {ps_r, pe_r + 32'd2 + qe_r};
                // close row q: shift rows above down
                ptr_nxt = lo_r + CntW'(1); lim_nxt = cnt_r;
                cnt_nxt = cnt_r - CntW'(1);
                state_nxt = S_SHDN;
              end else begin
                nwv_nxt = 1'b1; nwa_nxt = p[IdxW-1:0];
                nw_nxt = {ps_r, pe_r + 32'd1};
              end
            end else if (has_q && {1'b0, qs_r} == {1'b0, key_r} + 33'd1) begin
              nwv_nxt = 1'b1; nwa_nxt = lo_r[IdxW-1:0];
              nw_nxt = {key_r, qe_r + 32'd1};
            end else if (cnt_r >= CntW'(MaxRows)) begin
              st_nxt = ST_FULL;
            end else begin
              nwv_nxt = 1'b1; nwa_nxt = lo_r[IdxW-1:0];
              nw_nxt = {key_r, 32'd0};
              ptr_nxt = cnt_r; lim_nxt = lo_r;
              cnt_nxt = cnt_r + CntW'(1);
              state_nxt = S_SHUP;
            end
          end
        end else if (cmd_r == CMD_DEL) begin
          if (!hit_r) begin
            st_nxt = ST_ABSENT;
          end else if (key_r == ps_r) begin
            if (pe_r == '0) begin
              ptr_nxt = lo_r; lim_nxt = cnt_r;
              cnt_nxt = cnt_r - CntW'(1);
              state_nxt = S_SHDN;
            end else begin
              nwv_nxt = 1'b1; nwa_nxt = p[IdxW-1:0];
              nw_nxt = {ps_r + 32'd1, pe_r - 32'd1};
            end
          end else if ({1'b0, key_r} == pend) begin
            nwv_nxt = 1'b1; nwa_nxt = p[IdxW-1:0];
            nw_nxt = {ps_r, pe_r - 32'd1};
          end else if (cnt_r >= CntW'(MaxRows)) begin
            st_nxt = ST_FULL;
          end else begin
            nwv_nxt = 1'b1; nwa_nxt = p[IdxW-1:0];
            nw_nxt = {ps_r, key_r - ps_r - 32'd1};
            nw2v_nxt = 1'b1; nw2a_nxt = lo_r[IdxW-1:0];
            nw2_nxt = {key_r + 32'd1, pend[31:0] - (key_r + 32'd1)};
            ptr_nxt = cnt_r; lim_nxt = lo_r;
            cnt_nxt = cnt_r + CntW'(1);
            state_nxt = S_SHUP;
          end
        end
      end
      // move rows [lim, ptr) up by one, top first: read ptr-1, write ptr
      S_SHUP: begin
        if (ptr_r > lim_r) begin
          mreq.raddr = IdxW'(ptr_r - CntW'(1));
          state_nxt = S_SHUP;
          ptr_nxt = ptr_r - CntW'(1);
          lim_nxt = lim_r;
        end else begin
          state_nxt = S_WR;
        end
        // write of the row read last cycle; cnt_r already holds the new count
        if (ptr_r + CntW'(1) < cnt_r) begin
          mreq.we = 1'b1;
          mreq.waddr = IdxW'(ptr_r + CntW'(1));
          mreq.wdata = rdata;
        end
      end
      // move rows [ptr, lim) down by one: read ptr, write ptr-1
      S_SHDN: begin
        if (ptr_r < lim_r) begin
          mreq.raddr = ptr_r[IdxW-1:0];
          ptr_nxt = ptr_r + CntW'(1);
        end else begin
          state_nxt = S_WR;
        end
        if (ptr_r != lo_r + CntW'(nwv_r) && ptr_r > lo_r + CntW'(nwv_r)) begin
          mreq.we = 1'b1;
          mreq.waddr = IdxW'(ptr_r - CntW'(2));
          mreq.wdata = rdata;
        end
      end
      S_WR: begin
        if (nwv_r) begin
          mreq.we = 1'b1; mreq.waddr = nwa_r; mreq.wdata = nw_r;
          nwv_nxt = 1'b0;
        end else if (nw2v_r) begin
          mreq.we = 1'b1; mreq.waddr = nw2a_r; mreq.wdata = nw2_r;
          nw2v_nxt = 1'b0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        done = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_status    = st_r;
  assign out_hit       = hit_r;
  assign out_row_index = hit_r ? p[7:0] : 8'd0;
  assign out_rows_used = 9'(cnt_r);

  `ARST_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accept must raise busy")
  `ARST_ASSERT_IMPL(a_cnt_max, clk, rst_n, cnt_r <= CntW'(MaxRows), "row count overflow")
  `ARST_ASSERT_IMPL(a_done_busy, clk, rst_n, done |-> busy, "done outside a command")
  `ARST_ASSERT_IMPL(a_full_cnt, clk, rst_n,
    done && st_r == ST_FULL |-> cnt_r == CntW'(MaxRows), "full reported below capacity")
endmodule
